/* design/i2cbcd_pkg.sv */
// Shared types and constants for the I2C BCD register access master.
// Used by the front, queue, back and top modules; no dependencies.
package i2cbcd_pkg;

  // Item classes decided by the front end
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  // Action codes on the input channel
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Classified item passed from front to back
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  reg_addr;
    logic [7:0]  bcd;
    logic        sda;
  } item_t;

  localparam int unsigned ItemW = $bits(item_t);

  // Slave address after reset
  localparam logic [6:0] DEV_ADDR_RESET = 7'd104;

  // Bus phase codes
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_ST_SETUP = 4'd1;
  localparam logic [3:0] PH_ST_FALL  = 4'd2;
  localparam logic [3:0] PH_ST_HOLD  = 4'd3;
  localparam logic [3:0] PH_TX_LOW   = 4'd4;
  localparam logic [3:0] PH_TX_HIGH  = 4'd5;
  localparam logic [3:0] PH_TA_LOW   = 4'd6;
  localparam logic [3:0] PH_TA_HIGH  = 4'd7;
  localparam logic [3:0] PH_RS_PREP  = 4'd8;
  localparam logic [3:0] PH_RX_LOW   = 4'd9;
  localparam logic [3:0] PH_RX_HIGH  = 4'd10;
  localparam logic [3:0] PH_NK_LOW   = 4'd11;
  localparam logic [3:0] PH_NK_HIGH  = 4'd12;
  localparam logic [3:0] PH_SP_LOW   = 4'd13;
  localparam logic [3:0] PH_SP_RISE  = 4'd14;
  localparam logic [3:0] PH_SP_DONE  = 4'd15;

  // Byte positions within a transaction
  localparam logic [1:0] BYTE_ADDR = 2'd0;
  localparam logic [1:0] BYTE_REG  = 2'd1;
  localparam logic [1:0] BYTE_LAST = 2'd2;

  // Bits per byte, counted up to this value
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

/* design/i2cbcd_front.sv */
// Front end: classifies an input item and packs the write value as BCD.
// Depends on i2cbcd_pkg.
module i2cbcd_front (
  input  logic [1:0]          action_i,
  input  logic [7:0]          reg_addr_i,
  input  logic [6:0]          write_value_i,
  input  logic                sda_in_i,
  output i2cbcd_pkg::item_t   item_o
);

  logic [14:0] quot_prod;
  logic [3:0]  tens;
  logic [6:0]  tens_x10;
  logic [6:0]  ones;

  // Divide by ten through the reciprocal 205/2048 (exact below 1029)
  assign quot_prod = 15'(write_value_i) * 15'd205;
  assign tens      = quot_prod[14:11];
  assign tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
  assign ones      = write_value_i - tens_x10;

  // Decode the action code
  always_comb begin
    item_o.reg_addr = reg_addr_i;
    item_o.bcd      = {tens, ones[3:0]};
    item_o.sda      = sda_in_i;
    case (action_i)
      i2cbcd_pkg::ACT_TICK:  item_o.kind = i2cbcd_pkg::KIND_TICK;
      i2cbcd_pkg::ACT_WRITE: item_o.kind = i2cbcd_pkg::KIND_WRITE;
      i2cbcd_pkg::ACT_READ:  item_o.kind = i2cbcd_pkg::KIND_READ;
      default:               item_o.kind = i2cbcd_pkg::KIND_NOP;
    endcase
  end

endmodule

/* design/i2cbcd_queue.sv */
// Two-entry item queue between the front end and the bus sequencer.
// Depends on i2cbcd_pkg.
module i2cbcd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  i2cbcd_pkg::item_t   push_item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output i2cbcd_pkg::item_t   head_o
);

  localparam int unsigned Depth = 2;

  i2cbcd_pkg::item_t  mem_q [Depth];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = count_q == 2'(Depth);
  assign empty_o = count_q == 2'd0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* design/i2cbcd_back.sv */
// Back end: bus phase sequencer and result register with stall handling.
// Depends on i2cbcd_pkg.
module i2cbcd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [6:0]          cfg_wdata_i,
  input  logic                item_valid_i,
  input  i2cbcd_pkg::item_t   item_i,
  output logic                item_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                scl_level_o,
  output logic                sda_level_o,
  output logic                sda_drive_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic [7:0]          read_value_o
);

  logic [6:0] dev_addr_q;
  logic [3:0] phase_q, phase_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic [1:0] byte_idx_q, byte_idx_d;
  logic [7:0] shift_q, shift_d;
  logic       is_read_q, is_read_d;
  logic [7:0] held_reg_q, held_reg_d;
  logic [7:0] held_bcd_q, held_bcd_d;
  logic [7:0] last_read_q, last_read_d;
  logic       out_valid_q;
  logic       scl_q, sda_q, drv_q, busy_q, done_q;
  logic       scl, sda, drv, done;
  logic [3:0] bit_cnt_inc;
  logic [7:0] hi_x10;
  logic       is_cmd;

  // Take an item whenever the result register is free or being drained
  assign item_pop_o  = item_valid_i && (!out_valid_q || !out_stall_i);
  assign bit_cnt_inc = bit_cnt_q + 4'd1;
  assign hi_x10      = {1'b0, shift_q[7:4], 3'b000} + {3'b000, shift_q[7:4], 1'b0};
  assign is_cmd      = item_i.kind == i2cbcd_pkg::KIND_WRITE ||
                       item_i.kind == i2cbcd_pkg::KIND_READ;

  // Line levels of the current phase
  always_comb begin
    scl = 1'b1;
    sda = 1'b1;
    drv = 1'b1;
    case (phase_q)
      i2cbcd_pkg::PH_ST_FALL: sda = 1'b0;
      i2cbcd_pkg::PH_ST_HOLD: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      i2cbcd_pkg::PH_TX_LOW: begin
        scl = 1'b0;
        sda = shift_q[7];
      end
      i2cbcd_pkg::PH_TX_HIGH: sda = shift_q[7];
      i2cbcd_pkg::PH_TA_LOW: begin
        scl = 1'b0;
        drv = 1'b0;
      end
      i2cbcd_pkg::PH_TA_HIGH: drv = 1'b0;
      i2cbcd_pkg::PH_RS_PREP: scl = 1'b0;
      i2cbcd_pkg::PH_RX_LOW: begin
        scl = 1'b0;
        drv = 1'b0;
      end
      i2cbcd_pkg::PH_RX_HIGH: drv = 1'b0;
      i2cbcd_pkg::PH_NK_LOW: scl = 1'b0;
      i2cbcd_pkg::PH_SP_LOW: begin
        scl = 1'b0;
        sda = 1'b0;
      end
      i2cbcd_pkg::PH_SP_RISE: sda = 1'b0;
      default: ;
    endcase
  end

  // Sequencer next state
  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    byte_idx_d  = byte_idx_q;
    shift_d     = shift_q;
    is_read_d   = is_read_q;
    held_reg_d  = held_reg_q;
    held_bcd_d  = held_bcd_q;
    last_read_d = last_read_q;
    done        = 1'b0;
    if (is_cmd && phase_q == i2cbcd_pkg::PH_IDLE) begin
      // Latch a new command; its first phase is START setup
      held_reg_d = item_i.reg_addr;
      held_bcd_d = item_i.bcd;
      is_read_d  = item_i.kind == i2cbcd_pkg::KIND_READ;
      byte_idx_d = i2cbcd_pkg::BYTE_ADDR;
      bit_cnt_d  = 4'd0;
      shift_d    = 8'd0;
      phase_d    = i2cbcd_pkg::PH_ST_SETUP;
    end else if (item_i.kind == i2cbcd_pkg::KIND_TICK &&
                 phase_q != i2cbcd_pkg::PH_IDLE) begin
      case (phase_q)
        i2cbcd_pkg::PH_ST_SETUP: phase_d = i2cbcd_pkg::PH_ST_FALL;
        i2cbcd_pkg::PH_ST_FALL:  phase_d = i2cbcd_pkg::PH_ST_HOLD;
        i2cbcd_pkg::PH_ST_HOLD: begin
          shift_d   = {dev_addr_q, byte_idx_q == i2cbcd_pkg::BYTE_LAST};
          bit_cnt_d = 4'd0;
          phase_d   = i2cbcd_pkg::PH_TX_LOW;
        end
        i2cbcd_pkg::PH_TX_LOW: phase_d = i2cbcd_pkg::PH_TX_HIGH;
        i2cbcd_pkg::PH_TX_HIGH: begin
          shift_d   = {shift_q[6:0], 1'b0};
          bit_cnt_d = bit_cnt_inc;
          phase_d   = (bit_cnt_inc >= i2cbcd_pkg::BITS_PER_BYTE) ?
                      i2cbcd_pkg::PH_TA_LOW : i2cbcd_pkg::PH_TX_LOW;
        end
        i2cbcd_pkg::PH_TA_LOW: phase_d = i2cbcd_pkg::PH_TA_HIGH;
        i2cbcd_pkg::PH_TA_HIGH: begin
          bit_cnt_d = 4'd0;
          if (byte_idx_q == i2cbcd_pkg::BYTE_ADDR) begin
            byte_idx_d = i2cbcd_pkg::BYTE_REG;
            shift_d    = held_reg_q;
            phase_d    = i2cbcd_pkg::PH_TX_LOW;
          end else if (byte_idx_q == i2cbcd_pkg::BYTE_REG) begin
            byte_idx_d = i2cbcd_pkg::BYTE_LAST;
            if (is_read_q) begin
              phase_d = i2cbcd_pkg::PH_RS_PREP;
            end else begin
              shift_d = held_bcd_q;
              phase_d = i2cbcd_pkg::PH_TX_LOW;
            end
          end else begin
            phase_d = is_read_q ? i2cbcd_pkg::PH_RX_LOW : i2cbcd_pkg::PH_SP_LOW;
            shift_d = 8'd0;
          end
        end
        i2cbcd_pkg::PH_RS_PREP: phase_d = i2cbcd_pkg::PH_ST_SETUP;
        i2cbcd_pkg::PH_RX_LOW:  phase_d = i2cbcd_pkg::PH_RX_HIGH;
        i2cbcd_pkg::PH_RX_HIGH: begin
          shift_d   = {shift_q[6:0], item_i.sda};
          bit_cnt_d = bit_cnt_inc;
          phase_d   = (bit_cnt_inc >= i2cbcd_pkg::BITS_PER_BYTE) ?
                      i2cbcd_pkg::PH_NK_LOW : i2cbcd_pkg::PH_RX_LOW;
        end
        i2cbcd_pkg::PH_NK_LOW:  phase_d = i2cbcd_pkg::PH_NK_HIGH;
        i2cbcd_pkg::PH_NK_HIGH: phase_d = i2cbcd_pkg::PH_SP_LOW;
        i2cbcd_pkg::PH_SP_LOW:  phase_d = i2cbcd_pkg::PH_SP_RISE;
        i2cbcd_pkg::PH_SP_RISE: phase_d = i2cbcd_pkg::PH_SP_DONE;
        i2cbcd_pkg::PH_SP_DONE: begin
          if (is_read_q) begin
            last_read_d = {4'd0, shift_q[3:0]} + hi_x10;
          end
          done    = 1'b1;
          phase_d = i2cbcd_pkg::PH_IDLE;
        end
        default: phase_d = i2cbcd_pkg::PH_IDLE;
      endcase
    end
  end

  // Hold the slave address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= i2cbcd_pkg::DEV_ADDR_RESET;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // Advance the sequencer on each taken item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2cbcd_pkg::PH_IDLE;
      bit_cnt_q   <= 4'd0;
      byte_idx_q  <= i2cbcd_pkg::BYTE_ADDR;
      shift_q     <= 8'd0;
      is_read_q   <= 1'b0;
      held_reg_q  <= 8'd0;
      held_bcd_q  <= 8'd0;
      last_read_q <= 8'd0;
    end else if (item_pop_o) begin
      phase_q     <= phase_d;
      bit_cnt_q   <= bit_cnt_d;
      byte_idx_q  <= byte_idx_d;
      shift_q     <= shift_d;
      is_read_q   <= is_read_d;
      held_reg_q  <= held_reg_d;
      held_bcd_q  <= held_bcd_d;
      last_read_q <= last_read_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; levels of a fresh command are those of START setup
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      scl_q  <= (is_cmd && phase_q == i2cbcd_pkg::PH_IDLE) ? 1'b1 : scl;
      sda_q  <= (is_cmd && phase_q == i2cbcd_pkg::PH_IDLE) ? 1'b1 : sda;
      drv_q  <= (is_cmd && phase_q == i2cbcd_pkg::PH_IDLE) ? 1'b1 : drv;
      busy_q <= phase_d != i2cbcd_pkg::PH_IDLE;
      done_q <= done;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign scl_level_o  = scl_q;
  assign sda_level_o  = sda_q;
  assign sda_drive_o  = drv_q;
  assign busy_res_o   = busy_q;
  assign done_res_o   = done_q;
  assign read_value_o = last_read_q;

endmodule

/* design/i2c_bcd_register_access_master.sv */
// Top level of the I2C BCD register access master: front, queue, back.
// Depends on i2cbcd_pkg, i2cbcd_front, i2cbcd_queue, i2cbcd_back.
//
//   port group   direction   handshake              payload
//   in           to block    in_valid_i/in_stall_o  action, reg_addr, write_value, sda_in
//   out          from block  out_valid_o/out_stall_i scl/sda levels, drive, busy, done, read
//   cfg          to block    cfg_we_i               cfg_wdata_i (device address)
//
// One item per clock sustained while the output is not stalled; each result passes
// the queue write, then the sequencer and result register, after its item is accepted.
// The bus sequencer advances at most one phase per taken item.
// Reset is asynchronous and active low; it empties the queue and returns to idle.
// A stalled output holds its result; the two-entry queue keeps accepting until full.
module i2c_bcd_register_access_master (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [7:0] reg_addr_i,
  input  logic [6:0] write_value_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       scl_level_o,
  output logic       sda_level_o,
  output logic       sda_drive_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] read_value_o
);

  i2cbcd_pkg::item_t front_item;
  i2cbcd_pkg::item_t head_item;
  logic              q_full, q_empty, q_pop;

  // Classify incoming items
  i2cbcd_front u_front (
    .action_i      (action_i),
    .reg_addr_i    (reg_addr_i),
    .write_value_i (write_value_i),
    .sda_in_i      (sda_in_i),
    .item_o        (front_item)
  );

  // Buffer classified items
  i2cbcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_item_i (front_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_item)
  );

  assign in_stall_o = q_full;

  // Run the bus phases
  i2cbcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (!q_empty),
    .item_i       (head_item),
    .item_pop_o   (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .scl_level_o  (scl_level_o),
    .sda_level_o  (sda_level_o),
    .sda_drive_o  (sda_drive_o),
    .busy_res_o   (busy_res_o),
    .done_res_o   (done_res_o),
    .read_value_o (read_value_o)
  );

endmodule

/* test/i2c_bcd_register_access_master_tb.sv */
`timescale 1ns / 1ps
// Testbench for the I2C BCD register access master: queue-fed driver, result checker.
// Predicts every bus phase in the testbench itself; depends on i2cbcd_pkg and the DUT.
module i2c_bcd_register_access_master_tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_REPORTS = 30;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] reg_addr;
    logic [6:0] write_value;
    logic       sda_in;
  } cmd_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drive;
    logic       busy;
    logic       done;
    logic [7:0] rd_val;
  } bus_result_t;

  // DUT connections, inputs known from time zero
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] action_i = i2cbcd_pkg::ACT_TICK;
  logic [7:0] reg_addr_i = '0;
  logic [6:0] write_value_i = '0;
  logic       sda_in_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       scl_level_o;
  logic       sda_level_o;
  logic       sda_drive_o;
  logic       busy_res_o;
  logic       done_res_o;
  logic [7:0] read_value_o;

  // Item and expected-phase stores
  cmd_item_t   pending_items[$];
  bus_result_t expected_phases[$];
  cmd_item_t   next_item;
  bus_result_t seen_phase;

  // Bus sequencer state as the testbench tracks it
  logic [6:0] dev_addr;
  logic [3:0] bus_phase;
  logic [3:0] bit_cnt;
  logic [1:0] byte_pos;
  logic [7:0] shreg;
  logic       read_op;
  logic [7:0] reg_hold;
  logic [7:0] bcd_hold;
  logic [7:0] read_result;

  // Idling control
  int unsigned send_idle_pct = 28;
  int unsigned recv_stall_pct = 61;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;

  i2c_bcd_register_access_master DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .reg_addr_i    (reg_addr_i),
    .write_value_i (write_value_i),
    .sda_in_i      (sda_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scl_level_o   (scl_level_o),
    .sda_level_o   (sda_level_o),
    .sda_drive_o   (sda_drive_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .read_value_o  (read_value_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // SCL/SDA levels of the phase currently held
  function automatic void phase_levels(output bus_result_t r);
    r = '0;
    r.scl = 1'b1;
    r.sda = 1'b1;
    r.drive = 1'b1;
    case (bus_phase)
      i2cbcd_pkg::PH_ST_FALL: r.sda = 1'b0;
      i2cbcd_pkg::PH_ST_HOLD: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
      end
      i2cbcd_pkg::PH_TX_LOW: begin
        r.scl = 1'b0;
        r.sda = shreg[7];
      end
      i2cbcd_pkg::PH_TX_HIGH: r.sda = shreg[7];
      i2cbcd_pkg::PH_TA_LOW: begin
        r.scl = 1'b0;
        r.drive = 1'b0;
      end
      i2cbcd_pkg::PH_TA_HIGH: r.drive = 1'b0;
      i2cbcd_pkg::PH_RS_PREP: r.scl = 1'b0;
      i2cbcd_pkg::PH_RX_LOW: begin
        r.scl = 1'b0;
        r.drive = 1'b0;
      end
      i2cbcd_pkg::PH_RX_HIGH: r.drive = 1'b0;
      i2cbcd_pkg::PH_NK_LOW: r.scl = 1'b0;
      i2cbcd_pkg::PH_SP_LOW: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
      end
      i2cbcd_pkg::PH_SP_RISE: r.sda = 1'b0;
      default: ;
    endcase
  endfunction

  // Execute the held phase and move to the next one
  task automatic advance_phase(input logic sda, output logic done);
    done = 1'b0;
    case (bus_phase)
      i2cbcd_pkg::PH_ST_SETUP: bus_phase = i2cbcd_pkg::PH_ST_FALL;
      i2cbcd_pkg::PH_ST_FALL: bus_phase = i2cbcd_pkg::PH_ST_HOLD;
      i2cbcd_pkg::PH_ST_HOLD: begin
        shreg = {dev_addr, byte_pos == i2cbcd_pkg::BYTE_LAST};
        bit_cnt = '0;
        bus_phase = i2cbcd_pkg::PH_TX_LOW;
      end
      i2cbcd_pkg::PH_TX_LOW: bus_phase = i2cbcd_pkg::PH_TX_HIGH;
      i2cbcd_pkg::PH_TX_HIGH: begin
        shreg = shreg << 1;
        bit_cnt = bit_cnt + 4'd1;
        bus_phase = (bit_cnt >= i2cbcd_pkg::BITS_PER_BYTE) ?
                    i2cbcd_pkg::PH_TA_LOW : i2cbcd_pkg::PH_TX_LOW;
      end
      i2cbcd_pkg::PH_TA_LOW: bus_phase = i2cbcd_pkg::PH_TA_HIGH;
      i2cbcd_pkg::PH_TA_HIGH: begin
        bit_cnt = '0;
        if (byte_pos == i2cbcd_pkg::BYTE_ADDR) begin
          byte_pos = i2cbcd_pkg::BYTE_REG;
          shreg = reg_hold;
          bus_phase = i2cbcd_pkg::PH_TX_LOW;
        end else if (byte_pos == i2cbcd_pkg::BYTE_REG) begin
          byte_pos = i2cbcd_pkg::BYTE_LAST;
          if (read_op) begin
            bus_phase = i2cbcd_pkg::PH_RS_PREP;
          end else begin
            shreg = bcd_hold;
            bus_phase = i2cbcd_pkg::PH_TX_LOW;
          end
        end else begin
          bus_phase = read_op ? i2cbcd_pkg::PH_RX_LOW : i2cbcd_pkg::PH_SP_LOW;
          shreg = '0;
        end
      end
      i2cbcd_pkg::PH_RS_PREP: bus_phase = i2cbcd_pkg::PH_ST_SETUP;
      i2cbcd_pkg::PH_RX_LOW: bus_phase = i2cbcd_pkg::PH_RX_HIGH;
      i2cbcd_pkg::PH_RX_HIGH: begin
        shreg = {shreg[6:0], sda};
        bit_cnt = bit_cnt + 4'd1;
        bus_phase = (bit_cnt >= i2cbcd_pkg::BITS_PER_BYTE) ?
                    i2cbcd_pkg::PH_NK_LOW : i2cbcd_pkg::PH_RX_LOW;
      end
      i2cbcd_pkg::PH_NK_LOW: bus_phase = i2cbcd_pkg::PH_NK_HIGH;
      i2cbcd_pkg::PH_NK_HIGH: bus_phase = i2cbcd_pkg::PH_SP_LOW;
      i2cbcd_pkg::PH_SP_LOW: bus_phase = i2cbcd_pkg::PH_SP_RISE;
      i2cbcd_pkg::PH_SP_RISE: bus_phase = i2cbcd_pkg::PH_SP_DONE;
      i2cbcd_pkg::PH_SP_DONE: begin
        if (read_op) begin
          read_result = 8'(shreg[3:0] + shreg[7:4] * 10);
        end
        done = 1'b1;
        bus_phase = i2cbcd_pkg::PH_IDLE;
      end
      default: bus_phase = i2cbcd_pkg::PH_IDLE;
    endcase
  endtask

  // Predict the result of one item and queue both
  task automatic push_item(input logic [1:0] act, input logic [7:0] ra,
                           input logic [6:0] wv, input logic sd);
    cmd_item_t   it;
    bus_result_t res;
    logic        done;
    it = '{action: act, reg_addr: ra, write_value: wv, sda_in: sd};
    done = 1'b0;
    if ((act == i2cbcd_pkg::ACT_WRITE || act == i2cbcd_pkg::ACT_READ) &&
        bus_phase == i2cbcd_pkg::PH_IDLE) begin
      reg_hold = ra;
      bcd_hold = 8'(((wv / 10) << 4) | (wv % 10));
      read_op = (act == i2cbcd_pkg::ACT_READ);
      byte_pos = i2cbcd_pkg::BYTE_ADDR;
      bit_cnt = '0;
      shreg = '0;
      bus_phase = i2cbcd_pkg::PH_ST_SETUP;
      phase_levels(res);
    end else if (act == i2cbcd_pkg::ACT_TICK) begin
      phase_levels(res);
      if (bus_phase != i2cbcd_pkg::PH_IDLE) begin
        advance_phase(sd, done);
      end
    end else begin
      phase_levels(res);
    end
    res.busy = (bus_phase != i2cbcd_pkg::PH_IDLE);
    res.done = done;
    res.rd_val = read_result;
    pending_items.push_back(it);
    expected_phases.push_back(res);
  endtask

  // Tick until the open transaction ends; sda_mode 0/1 fixed level, 2 random
  task automatic tick_to_idle(input int sda_mode);
    while (bus_phase != i2cbcd_pkg::PH_IDLE) begin
      push_item(i2cbcd_pkg::ACT_TICK, 8'($urandom), 7'($urandom),
                (sda_mode == 2) ? 1'($urandom) : 1'(sda_mode));
    end
  endtask

  // Close the transaction, let every result come back, then settle
  task automatic drain;
    tick_to_idle(2);
    while (expected_phases.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_device_address(input logic [6:0] a);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dev_addr = a;
  endtask

  // Mostly whole transactions with random content, plus ignored noise
  task automatic random_traffic(input int unsigned n);
    int unsigned cnt;
    int unsigned pick;
    logic [6:0]  wv;
    cnt = 0;
    while (cnt < n) begin
      pick = $urandom_range(99);
      wv = ($urandom_range(99) < 85) ? 7'($urandom_range(99)) : 7'($urandom_range(127, 100));
      if (bus_phase == i2cbcd_pkg::PH_IDLE) begin
        if (pick < 80) begin
          push_item(($urandom_range(1) != 0) ? i2cbcd_pkg::ACT_READ : i2cbcd_pkg::ACT_WRITE,
                    8'($urandom), wv, 1'($urandom));
          cnt++;
        end else if (pick < 90) begin
          push_item(i2cbcd_pkg::ACT_TICK, 8'($urandom), wv, 1'($urandom));
        end else begin
          push_item(ACT_UNUSED, 8'($urandom), wv, 1'($urandom));
        end
      end else begin
        if (pick < 94) begin
          push_item(i2cbcd_pkg::ACT_TICK, 8'($urandom), wv, 1'($urandom));
          cnt++;
        end else begin
          push_item(2'($urandom_range(3, 1)), 8'($urandom), wv, 1'($urandom));
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input bus_result_t got,
                                 input bus_result_t want);
    if (mismatch_cnt < MAX_REPORTS) begin
      $write("[%0t] %s: got scl=%b sda=%b drv=%b busy=%b done=%b rd=%0d, ",
             $time, what, got.scl, got.sda, got.drive, got.busy, got.done, got.rd_val);
      $display("want scl=%b sda=%b drv=%b busy=%b done=%b rd=%0d",
               want.scl, want.sda, want.drive, want.busy, want.done, want.rd_val);
    end
    mismatch_cnt++;
  endtask

  // Driver: offer the next item once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        in_valid_i <= 1'b1;
        action_i <= next_item.action;
        reg_addr_i <= next_item.reg_addr;
        write_value_i <= next_item.write_value;
        sda_in_i <= next_item.sda_in;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall, or a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_phase = '{scl: scl_level_o, sda: sda_level_o, drive: sda_drive_o,
                     busy: busy_res_o, done: done_res_o, rd_val: read_value_o};
      if (expected_phases.size() == 0) begin
        report_mismatch("unexpected result", seen_phase, '0);
      end else if (seen_phase !== expected_phases[0]) begin
        report_mismatch("result mismatch", seen_phase, expected_phases.pop_front());
      end else begin
        void'(expected_phases.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus: directed transactions, then three random phases
  initial begin
    dev_addr = i2cbcd_pkg::DEV_ADDR_RESET;
    bus_phase = i2cbcd_pkg::PH_IDLE;
    bit_cnt = '0;
    byte_pos = i2cbcd_pkg::BYTE_ADDR;
    shreg = '0;
    read_op = 1'b0;
    reg_hold = '0;
    bcd_hold = '0;
    read_result = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle ticks and the unused action while idle
    push_item(i2cbcd_pkg::ACT_TICK, 8'h00, 7'd0, 1'b0);
    push_item(i2cbcd_pkg::ACT_TICK, 8'hFF, 7'd127, 1'b1);
    push_item(ACT_UNUSED, 8'h3C, 7'd50, 1'b1);
    // Write at the reset address, with commands ignored while busy
    push_item(i2cbcd_pkg::ACT_WRITE, 8'hFF, 7'd99, 1'b0);
    repeat (5) push_item(i2cbcd_pkg::ACT_TICK, 8'h00, 7'd0, 1'b1);
    push_item(i2cbcd_pkg::ACT_READ, 8'h12, 7'd1, 1'b0);
    push_item(i2cbcd_pkg::ACT_WRITE, 8'h34, 7'd2, 1'b1);
    push_item(ACT_UNUSED, 8'h56, 7'd3, 1'b0);
    tick_to_idle(2);
    push_item(i2cbcd_pkg::ACT_WRITE, 8'h00, 7'd0, 1'b0);
    tick_to_idle(0);
    // Value above ninety-nine
    push_item(i2cbcd_pkg::ACT_WRITE, 8'hA5, 7'd127, 1'b1);
    tick_to_idle(1);
    // Reads of all ones and all zeros, then random data
    push_item(i2cbcd_pkg::ACT_READ, 8'h5A, 7'd0, 1'b0);
    tick_to_idle(1);
    push_item(i2cbcd_pkg::ACT_READ, 8'hC3, 7'd99, 1'b1);
    tick_to_idle(0);
    push_item(i2cbcd_pkg::ACT_READ, 8'h7E, 7'd64, 1'b0);
    tick_to_idle(2);
    drain();

    // Phase one: address zero, sender idles less than receiver
    write_device_address(7'd0);
    random_traffic(230);
    drain();

    // Phase two: address all ones, the other way round
    send_idle_pct = 61;
    recv_stall_pct = 28;
    write_device_address(7'h7F);
    random_traffic(230);
    drain();

    // Phase three: random address, no idling, long hold-off at the start
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_device_address(7'($urandom));
    random_traffic(230);
    hold_req++;
    drain();

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
